// File: hw/rtl/lcm_pkg.sv
// shared types and constants of the least common multiple unit
package lcm_pkg;

  parameter int unsigned DefaultWidth = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIV,
    S_MINIT,
    S_MUL,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_GCD,
    CMD_DIV_INIT,
    CMD_DIV,
    CMD_MUL_INIT,
    CMD_MUL,
    CMD_RESULT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic gcd_done;
  } status_t;

endpackage

// File: hw/rtl/least_common_multiple_unit.sv
// top level of the least common multiple unit
// Least common multiple of two unsigned WIDTH-bit operands, one item at a time.
// A zero operand gives a zero result with overflow clear; otherwise the result
// is the true least common multiple, low WIDTH bits, with overflow set when it
// does not fit. An item runs through a binary gcd (one subtract or shift per
// cycle), a restoring divide of the first operand by the gcd, and a shift-add
// multiply by the second operand; an item with a zero operand skips the
// divide and the multiply.
// in_stall_o is low only while the controller is idle; the result sits in an
// output register, so the next item is taken while a result waits.
module least_common_multiple_unit #(
  parameter int unsigned WIDTH = lcm_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WIDTH-1:0] first_operand_i,
  input  logic [WIDTH-1:0] second_operand_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] multiple_value_o,
  output logic             overflow_o
);

  // commands from the controller, status back from the datapath
  lcm_pkg::cmd_t    cmd;
  lcm_pkg::status_t status;

  // sequencing of gcd, divide, multiply and result hand-off
  lcm_controller #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // operand registers, shared arithmetic and the output register
  lcm_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .multiple_value_o (multiple_value_o),
    .overflow_o       (overflow_o)
  );

endmodule

// File: hw/rtl/lcm_datapath.sv
// datapath of the least common multiple unit: gcd, divider, multiplier, result register
module lcm_datapath #(
  parameter int unsigned WIDTH = lcm_pkg::DefaultWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcm_pkg::cmd_t      cmd_i,
  output lcm_pkg::status_t   status_o,
  input  logic [WIDTH-1:0]   first_operand_i,
  input  logic [WIDTH-1:0]   second_operand_i,
  output logic [WIDTH-1:0]   multiple_value_o,
  output logic               overflow_o
);

  localparam int unsigned KW = $clog2(WIDTH);

  logic [WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [WIDTH-1:0] x_q, x_d, y_q, y_d, d_q, d_d;
  logic [KW-1:0]    k_q, k_d;
  logic             zero_q, zero_d;
  logic [WIDTH-1:0] res_value_q, res_value_d;
  logic             res_over_q, res_over_d;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH-1:0] rem_diff;
  logic             quo_bit;
  logic [WIDTH:0]   mul_sum;

  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    x_d         = x_q;
    y_d         = y_q;
    d_d         = d_q;
    k_d         = k_q;
    zero_d      = zero_q;
    res_value_d = res_value_q;
    res_over_d  = res_over_q;

    // restoring divide step: remainder in y, quotient shifts into x
    rem_sh   = {y_q, x_q[WIDTH-1]};
    // only used when the subtraction fits, so the low bits suffice
    rem_diff = rem_sh[WIDTH-1:0] - d_q;
    quo_bit  = (rem_sh >= {1'b0, d_q});

    // shift-add multiply step: high half in y, multiplier and low half in d
    mul_sum = {1'b0, y_q} + (d_q[0] ? {1'b0, x_q} : {(WIDTH+1){1'b0}});

    unique case (cmd_i.op)
      lcm_pkg::CMD_LOAD: begin
        a_d    = first_operand_i;
        b_d    = second_operand_i;
        x_d    = first_operand_i;
        y_d    = second_operand_i;
        k_d    = '0;
        zero_d = (first_operand_i == '0) || (second_operand_i == '0);
      end
      lcm_pkg::CMD_GCD: begin
        priority if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + KW'(1);
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q > y_q) begin
          x_d = (x_q - y_q) >> 1;
        end else begin
          y_d = (y_q - x_q) >> 1;
        end
      end
      lcm_pkg::CMD_DIV_INIT: begin
        d_d = x_q << k_q;
        x_d = a_q;
        y_d = '0;
      end
      lcm_pkg::CMD_DIV: begin
        y_d = quo_bit ? rem_diff : rem_sh[WIDTH-1:0];
        x_d = {x_q[WIDTH-2:0], quo_bit};
      end
      lcm_pkg::CMD_MUL_INIT: begin
        y_d = '0;
        d_d = b_q;
      end
      lcm_pkg::CMD_MUL: begin
        y_d = mul_sum[WIDTH:1];
        d_d = {mul_sum[0], d_q[WIDTH-1:1]};
      end
      lcm_pkg::CMD_RESULT: begin
        res_value_d = zero_q ? '0 : d_q;
        res_over_d  = !zero_q && (y_q != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    x_q         <= x_d;
    y_q         <= y_d;
    d_q         <= d_d;
    k_q         <= k_d;
    zero_q      <= zero_d;
    res_value_q <= res_value_d;
    res_over_q  <= res_over_d;
  end

  assign status_o.zero     = zero_q;
  assign status_o.gcd_done = (x_q == y_q);
  assign multiple_value_o  = res_value_q;
  assign overflow_o        = res_over_q;

  // gcd working values never reach zero while stepping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == lcm_pkg::CMD_GCD) |-> (x_q != '0 && y_q != '0))
    else $error("gcd step on a zero value");

  // divisor is nonzero and remainder cleared once division starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == lcm_pkg::CMD_DIV_INIT) |=> (y_q == '0 && d_q != '0))
    else $error("bad divider start");

  // multiplier high half cleared and second operand loaded at start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == lcm_pkg::CMD_MUL_INIT) |=> (y_q == '0 && d_q == b_q))
    else $error("bad multiplier start");

endmodule

// File: hw/rtl/lcm_controller.sv
// controller state machine of the least common multiple unit
module lcm_controller #(
  parameter int unsigned WIDTH = lcm_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lcm_pkg::cmd_t    cmd_o,
  input  lcm_pkg::status_t status_i
);

  localparam int unsigned CntW = $clog2(WIDTH);

  lcm_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcm_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.op  = lcm_pkg::CMD_NONE;
    in_stall_o = (state_q != lcm_pkg::S_IDLE);

    unique case (state_q)
      lcm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = lcm_pkg::CMD_LOAD;
          state_d  = lcm_pkg::S_GCD;
        end
      end
      lcm_pkg::S_GCD: begin
        priority if (status_i.zero) begin
          state_d = lcm_pkg::S_DONE;
        end else if (status_i.gcd_done) begin
          cmd_o.op = lcm_pkg::CMD_DIV_INIT;
          cnt_d    = CntW'(WIDTH - 1);
          state_d  = lcm_pkg::S_DIV;
        end else begin
          cmd_o.op = lcm_pkg::CMD_GCD;
        end
      end
      lcm_pkg::S_DIV: begin
        cmd_o.op = lcm_pkg::CMD_DIV;
        cnt_d    = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = lcm_pkg::S_MINIT;
        end
      end
      lcm_pkg::S_MINIT: begin
        cmd_o.op = lcm_pkg::CMD_MUL_INIT;
        cnt_d    = CntW'(WIDTH - 1);
        state_d  = lcm_pkg::S_MUL;
      end
      lcm_pkg::S_MUL: begin
        cmd_o.op = lcm_pkg::CMD_MUL;
        cnt_d    = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = lcm_pkg::S_DONE;
        end
      end
      lcm_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op = lcm_pkg::CMD_RESULT;
          state_d  = lcm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lcm_pkg::S_IDLE;
      end
    endcase

    if (cmd_o.op == lcm_pkg::CMD_RESULT) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // a result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == lcm_pkg::CMD_RESULT) |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten");

  // an accepted item always starts the gcd phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcm_pkg::S_IDLE && in_valid_i) |=> (state_q == lcm_pkg::S_GCD))
    else $error("accepted item not started");

  // the multiply phase ends exactly when its count runs out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcm_pkg::S_MUL && cnt_q == '0) |=> (state_q == lcm_pkg::S_DONE))
    else $error("multiply phase did not finish");

endmodule

// File: verif/least_common_multiple_unit_tb.sv
// testbench of the least common multiple unit: directed table, then random operands
module least_common_multiple_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH = lcm_pkg::DefaultWidth;
  localparam int unsigned NumRows = 20;
  // receiver hold-off that outlasts one full item, so the block backs up
  localparam int unsigned HoldOffCycles = 600;
  // quiet cycles after the last result, a few times the slowest item
  localparam int unsigned TailCycles = 400;

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic             overflow;
  } lcm_result_t;

  // one directed item; want is only meaningful when known is set
  typedef struct packed {
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic             known;
    lcm_result_t      want;
  } lcm_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [WIDTH-1:0] first_operand_i = '0;
  logic [WIDTH-1:0] second_operand_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [WIDTH-1:0] multiple_value_o;
  logic             overflow_o;

  lcm_result_t pending_lcm_q[$];
  lcm_result_t oldest;
  int unsigned mismatch_count = 0;
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          rx_hold_req = 1'b0;

  // zero operands, all-ones, overflow at the top end, exact fits
  lcm_row_t directed_rows [NumRows] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0}},
    '{32'h0000_0000, 32'hffff_ffff, 1'b1, '{32'h0000_0000, 1'b0}},
    '{32'hffff_ffff, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0}},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b0}},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 1'b0}},
    '{32'h0000_0001, 32'hffff_ffff, 1'b1, '{32'hffff_ffff, 1'b0}},
    '{32'hffff_ffff, 32'h0000_0001, 1'b1, '{32'hffff_ffff, 1'b0}},
    '{32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'hffff_ffff, 1'b0}},
    '{32'hffff_ffff, 32'hffff_fffe, 1'b1, '{32'h0000_0002, 1'b1}},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b0}},
    '{32'h8000_0000, 32'h0000_0003, 1'b1, '{32'h8000_0000, 1'b1}},
    '{32'h5555_5555, 32'haaaa_aaaa, 1'b1, '{32'haaaa_aaaa, 1'b0}},
    '{32'h0000_ffff, 32'h0001_0001, 1'b1, '{32'hffff_ffff, 1'b0}},
    '{32'd12,        32'd18,        1'b0, '{32'h0000_0000, 1'b0}},
    '{32'd4,         32'd6,         1'b0, '{32'h0000_0000, 1'b0}},
    '{32'd7,         32'd13,        1'b0, '{32'h0000_0000, 1'b0}},
    '{32'h0001_0000, 32'h0001_0001, 1'b0, '{32'h0000_0000, 1'b0}},
    '{32'h7fff_ffff, 32'h0000_0002, 1'b0, '{32'h0000_0000, 1'b0}},
    '{32'h8000_0001, 32'h0000_0002, 1'b0, '{32'h0000_0000, 1'b0}},
    '{32'hffff_fffe, 32'h0000_0002, 1'b0, '{32'h0000_0000, 1'b0}}
  };

  least_common_multiple_unit #(
    .WIDTH(WIDTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .first_operand_i (first_operand_i),
    .second_operand_i(second_operand_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .multiple_value_o(multiple_value_o),
    .overflow_o      (overflow_o)
  );

  always #1 clk_i = ~clk_i;

  // euclid on the operands, then (a / g) * b at double width so nothing wraps
  function automatic lcm_result_t predict_lcm(input logic [WIDTH-1:0] a,
                                              input logic [WIDTH-1:0] b);
    logic [WIDTH-1:0]   x;
    logic [WIDTH-1:0]   y;
    logic [WIDTH-1:0]   r;
    logic [2*WIDTH-1:0] product;
    lcm_result_t        res;
    res = '0;
    if (a != '0 && b != '0) begin
      x = a;
      y = b;
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      product = {{WIDTH{1'b0}}, a / x} * {{WIDTH{1'b0}}, b};
      res.value = product[WIDTH-1:0];
      res.overflow = |product[2*WIDTH-1:WIDTH];
    end
    return res;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
  endfunction

  task automatic pick_operands(output logic [WIDTH-1:0] a, output logic [WIDTH-1:0] b);
    int unsigned kind;
    int unsigned k;
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      a = '0;
      b = $urandom;
    end else if (kind < 6) begin
      a = $urandom;
      b = '0;
    end else if (kind < 8) begin
      a = '0;
      b = '0;
    end else if (kind < 30) begin
      a = $urandom;
      b = $urandom;
    end else if (kind < 60) begin
      // shared factor so the gcd is usually far from one
      k = ($urandom >> $urandom_range(12, 31)) + 1;
      a = k * $urandom_range(1, 4095);
      b = k * $urandom_range(1, 4095);
    end else if (kind < 75) begin
      a = $urandom_range(1, 255);
      b = $urandom_range(1, 255);
    end else if (kind < 85) begin
      a = 1 << $urandom_range(0, 31);
      b = $urandom << $urandom_range(0, 31);
    end else begin
      a = $urandom >> $urandom_range(0, 31);
      b = $urandom >> $urandom_range(0, 31);
    end
  endtask

  // offer one item and hold it until the block takes it
  task automatic send_operands(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b,
                               input lcm_result_t want);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    first_operand_i <= a;
    second_operand_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_lcm_q.push_back(want);
  endtask

  // drop valid for some cycles, with junk on the operand lines
  task automatic idle_sender(input int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    first_operand_i <= $urandom;
    second_operand_i <= $urandom;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left = HoldOffCycles;
      end else if (stall_left == 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // every accepted result against the oldest outstanding expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lcm_q.size() == 0) begin
        $error("unexpected result: multiple_value %h overflow %b",
               multiple_value_o, overflow_o);
        mismatch_count++;
      end else begin
        oldest = pending_lcm_q.pop_front();
        if (multiple_value_o !== oldest.value) begin
          $error("multiple_value: expected %h, got %h", oldest.value, multiple_value_o);
          mismatch_count++;
        end
        if (overflow_o !== oldest.overflow) begin
          $error("overflow: expected %b, got %b", oldest.overflow, overflow_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL least_common_multiple_unit");
    $finish;
  end

  initial begin : stimulus
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    lcm_result_t      want;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      want = directed_rows[i].known ? directed_rows[i].want
                                    : predict_lcm(directed_rows[i].a, directed_rows[i].b);
      send_operands(directed_rows[i].a, directed_rows[i].b, want);
    end
    idle_sender(1);
    wait (pending_lcm_q.size() == 0);

    for (int i = 0; i < 700; i++) begin
      if (i == 150) begin
        tx_gap_pct = 30;
        rx_stall_pct = 25;
      end
      // block fills behind the held result and stalls its input
      if (i == 300) rx_hold_req = 1'b1;
      if (i == 450) begin
        idle_sender(1);
        wait (pending_lcm_q.size() == 0);
      end
      if (i == 520) begin
        tx_gap_pct = 0;
        rx_stall_pct = 60;
      end
      if (i == 620) begin
        tx_gap_pct = 50;
        rx_stall_pct = 0;
      end
      pick_operands(a, b);
      send_operands(a, b, predict_lcm(a, b));
      if ($urandom_range(0, 99) < tx_gap_pct) idle_sender(idle_len());
    end
    idle_sender(1);

    wait (pending_lcm_q.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS least_common_multiple_unit");
    end else begin
      $display("FAIL least_common_multiple_unit");
    end
    $finish;
  end

endmodule
